FILE: sv/assert_macros.svh
// assertion helpers shared by the rtl files
// each check is clocked on the rising edge and idle while reset is asserted
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");

`else

`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/dtsc_pkg.sv
// ----------------------------------------------------------------------------
// dtsc_pkg
// Types and codes shared by the dual timed switch controller files.
// ----------------------------------------------------------------------------
`default_nettype none

package dtsc_pkg;

	// one key-poll tick
	typedef struct packed {
		logic uv_key_pressed;
		logic o3_key_pressed;
		logic second_tick;
	} item_t;

	// one result per tick
	typedef struct packed {
		logic       uv_on;
		logic       o3_on;
		logic [1:0] uv_sound;
		logic [1:0] o3_sound;
	} result_t;

	// sound request codes
	localparam logic [1:0] SOUND_NONE = 2'd0;
	localparam logic [1:0] SOUND_ON   = 2'd1;
	localparam logic [1:0] SOUND_OFF  = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_SHORT_MIN   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG        = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_UV_DURATION = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_O3_DURATION = 2'd3;

	// register reset values
	localparam logic [7:0]  SHORT_MIN_RST   = 8'd10;
	localparam logic [7:0]  LONG_RST        = 8'd200;
	localparam logic [15:0] UV_DURATION_RST = 16'd180;
	localparam logic [15:0] O3_DURATION_RST = 16'd600;

endpackage

`default_nettype wire

FILE: sv/dtsc_channels.sv
// ----------------------------------------------------------------------------
// dtsc channels
// Valid/ready interfaces for the tick input and the result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtsc_item_if;
	logic           valid;
	logic           ready;
	dtsc_pkg::item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dtsc_result_if;
	logic              valid;
	logic              ready;
	dtsc_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/dual_timed_switch_controller_unit.sv
// ----------------------------------------------------------------------------
// dual_timed_switch_controller_unit
// Two-channel key-driven on/off controller with per-channel countdown timers.
// ----------------------------------------------------------------------------
// Each transfer on item is one key-poll tick; each produces exactly one
// transfer on result. The unit takes one tick per clock cycle while the
// result register is free or being read: a tick sits in an input register,
// where the press counters, the countdowns and the event decision are
// evaluated, and the outcome is loaded into the result register. The
// counters and countdowns are updated whenever the tick moves on. A held
// result only stalls the input register when that register is also full.
// Configuration writes through cfg_wr_en/cfg_index/cfg_wdata take effect at
// the write edge and should be made only while no tick is in flight.
`default_nettype none

`include "assert_macros.svh"

module dual_timed_switch_controller_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	dtsc_item_if.sink                                item,
	dtsc_result_if.source                            result,
	input  wire logic                                cfg_wr_en,
	input  wire logic [dtsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [dtsc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	typedef struct packed {
		logic [7:0]  cnt;
		logic [15:0] secs;
		logic [1:0]  snd;
	} chan_next_t;

	// one channel, one tick
	function automatic chan_next_t chan_step(
		input logic [7:0]  cnt,
		input logic [15:0] secs,
		input logic        pressed,
		input logic        sec,
		input logic [15:0] dur,
		input logic [7:0]  smin,
		input logic [7:0]  lng
	);
		chan_next_t  r;
		logic [15:0] secs_dec;
		logic        timeout;
		logic        ev;
		logic [7:0]  cnt_inc;
		secs_dec = secs;
		timeout  = 1'b0;
		ev       = 1'b0;
		cnt_inc  = cnt + 8'd1;
		r.cnt    = cnt;
		// countdown moves on the second pulse only
		if (sec && (secs != 16'd0)) begin
			secs_dec = secs - 16'd1;
			timeout  = (secs == 16'd1);
		end
		// press counter saturates at the long threshold
		if (pressed) begin
			if (cnt < lng) begin
				r.cnt = cnt_inc;
				ev    = (cnt_inc >= lng);
			end
		end else begin
			ev    = (cnt > smin) && (cnt < lng);
			r.cnt = 8'd0;
		end
		// toggle on event or timeout; timeout always switches off
		if (ev || timeout) begin
			if (timeout || (secs_dec != 16'd0)) begin
				r.secs = 16'd0;
				r.snd  = dtsc_pkg::SOUND_OFF;
			end else begin
				r.secs = dur;
				r.snd  = dtsc_pkg::SOUND_ON;
			end
		end else begin
			r.secs = secs_dec;
			r.snd  = dtsc_pkg::SOUND_NONE;
		end
		return r;
	endfunction

	logic [7:0]        short_min_q;
	logic [7:0]        long_q;
	logic [15:0]       uv_dur_q;
	logic [15:0]       o3_dur_q;
	logic [7:0]        uv_cnt_q;
	logic [7:0]        o3_cnt_q;
	logic [15:0]       uv_secs_q;
	logic [15:0]       o3_secs_q;
	logic              valid_s1;
	dtsc_pkg::item_t   item_s1;
	logic              res_valid_q;
	dtsc_pkg::result_t res_q;
	logic              advance;
	chan_next_t        uv_nx;
	chan_next_t        o3_nx;

	// input register moves into the result register when that one is free
	assign advance     = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready  = !valid_s1 || advance;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_min_q <= dtsc_pkg::SHORT_MIN_RST;
			long_q      <= dtsc_pkg::LONG_RST;
			uv_dur_q    <= dtsc_pkg::UV_DURATION_RST;
			o3_dur_q    <= dtsc_pkg::O3_DURATION_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				dtsc_pkg::REG_SHORT_MIN:   short_min_q <= cfg_wdata[7:0];
				dtsc_pkg::REG_LONG:        long_q      <= cfg_wdata[7:0];
				dtsc_pkg::REG_UV_DURATION: uv_dur_q    <= cfg_wdata;
				dtsc_pkg::REG_O3_DURATION: o3_dur_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// per-channel next state
	always_comb begin
		uv_nx = chan_step(uv_cnt_q, uv_secs_q, item_s1.uv_key_pressed,
			item_s1.second_tick, uv_dur_q, short_min_q, long_q);
		o3_nx = chan_step(o3_cnt_q, o3_secs_q, item_s1.o3_key_pressed,
			item_s1.second_tick, o3_dur_q, short_min_q, long_q);
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	// channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uv_cnt_q  <= 8'd0;
			o3_cnt_q  <= 8'd0;
			uv_secs_q <= 16'd0;
			o3_secs_q <= 16'd0;
		end else if (advance) begin
			uv_cnt_q  <= uv_nx.cnt;
			o3_cnt_q  <= o3_nx.cnt;
			uv_secs_q <= uv_nx.secs;
			o3_secs_q <= o3_nx.secs;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.uv_on    <= (uv_nx.secs != 16'd0);
			res_q.o3_on    <= (o3_nx.secs != 16'd0);
			res_q.uv_sound <= uv_nx.snd;
			res_q.o3_sound <= o3_nx.snd;
		end
	end

	// checks
	`ASSERT_SAME(a_off_sound_means_off, clk, arst_n, res_valid_q, !((res_q.uv_sound == dtsc_pkg::SOUND_OFF) && res_q.uv_on) && !((res_q.o3_sound == dtsc_pkg::SOUND_OFF) && res_q.o3_on))
	`ASSERT_SAME(a_sound_code_legal, clk, arst_n, res_valid_q, ((res_q.uv_sound == dtsc_pkg::SOUND_NONE) || (res_q.uv_sound == dtsc_pkg::SOUND_ON) || (res_q.uv_sound == dtsc_pkg::SOUND_OFF)) && ((res_q.o3_sound == dtsc_pkg::SOUND_NONE) || (res_q.o3_sound == dtsc_pkg::SOUND_ON) || (res_q.o3_sound == dtsc_pkg::SOUND_OFF)))
	`ASSERT_NEXT(a_state_holds_without_tick, clk, arst_n, !advance, $stable(uv_secs_q) && $stable(o3_secs_q) && $stable(uv_cnt_q) && $stable(o3_cnt_q))
	`ASSERT_NEXT(a_release_clears_count, clk, arst_n, advance && !item_s1.uv_key_pressed, uv_cnt_q == 8'd0)
	`ASSERT_NEXT(a_on_tracks_countdown, clk, arst_n, advance, (res_q.uv_on == (uv_secs_q != 16'd0)) && (res_q.o3_on == (o3_secs_q != 16'd0)))

endmodule

`default_nettype wire
